>>> rtl/crcfr_pkg.sv
package crcfr_pkg;

   localparam int FRAME_BYTES_DEFAULT = 11;
   localparam int CTRL_BYTES          = 6;
   localparam int NAMED_BYTES         = 9;
   localparam int POWER_POS           = 4;
   localparam int BTN_OFF_POS         = 6;
   localparam int BTN_PREPARE_POS     = 7;
   localparam int BTN_RACE_POS        = 8;

   localparam logic [7:0]  CRC_INIT = 8'hFF;
   localparam logic [7:0]  CRC_POLY = 8'h07;
   localparam logic [7:0]  BUTTON_PRESSED = 8'h01;
   localparam logic [7:0]  POWER_ON       = 8'h01;

   localparam logic [7:0]  IDLE_LIMIT_RESET   = 8'd11;
   localparam logic [15:0] REJECT_LIMIT_RESET = 16'd150;
   localparam logic [7:0]  END_MARKER_RESET   = 8'h17;
   localparam logic [15:0] REJECT_COUNT_MAX   = 16'hFFFF;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_OFF     = 2'd1;
   localparam logic [1:0] MODE_PREPARE = 2'd2;
   localparam logic [1:0] MODE_RACE    = 2'd3;

   typedef enum logic [1:0] {
      REG_IDLE_LIMIT   = 2'd0,
      REG_REJECT_LIMIT = 2'd1,
      REG_END_MARKER   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  idle_tick_limit;
      logic [15:0] reject_limit;
      logic [7:0]  end_marker;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic walk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic walk_last;
   } status_type;

   // One CRC-8 byte update, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/crcfr_channels.sv
interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface crcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic [7:0] half_throttle;
   logic [7:0] full_throttle;
   logic [7:0] horn_button;
   logic [7:0] speed_reset_button;
   logic [7:0] power_request;
   logic [7:0] supercap_close;
   logic [1:0] fuel_mode_code;
   logic       emergency_flag;
   logic       link_fault;

   modport source (
      output valid, output frame_ok, output half_throttle, output full_throttle,
      output horn_button, output speed_reset_button, output power_request,
      output supercap_close, output fuel_mode_code, output emergency_flag,
      output link_fault, input ready
   );
   modport sink (
      input valid, input frame_ok, input half_throttle, input full_throttle,
      input horn_button, input speed_reset_button, input power_request,
      input supercap_close, input fuel_mode_code, input emergency_flag,
      input link_fault, output ready
   );
endinterface

>>> rtl/crcfr_csr.sv
module crcfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crcfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output crcfr_pkg::cfg_type               cfg
);

   crcfr_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            crcfr_pkg::REG_IDLE_LIMIT:   cfg_in.idle_tick_limit = pwdata[7:0];
            crcfr_pkg::REG_REJECT_LIMIT: cfg_in.reject_limit    = pwdata[15:0];
            crcfr_pkg::REG_END_MARKER:   cfg_in.end_marker      = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         crcfr_pkg::REG_IDLE_LIMIT:   prdata = {24'd0, cfg_ff.idle_tick_limit};
         crcfr_pkg::REG_REJECT_LIMIT: prdata = {16'd0, cfg_ff.reject_limit};
         crcfr_pkg::REG_END_MARKER:   prdata = {24'd0, cfg_ff.end_marker};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_tick_limit <= crcfr_pkg::IDLE_LIMIT_RESET;
         cfg_ff.reject_limit    <= crcfr_pkg::REJECT_LIMIT_RESET;
         cfg_ff.end_marker      <= crcfr_pkg::END_MARKER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/crcfr_ctrl.sv
module crcfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  crcfr_pkg::status_type status,
   output crcfr_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.walk   = (state_ff == ST_WALK);
   assign cmd.finish = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.frame_end) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/crcfr_datapath.sv
module crcfr_datapath #(
   parameter int FRAME_BYTES = crcfr_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crcfr_pkg::cfg_type    cfg,
   input  crcfr_pkg::cmd_type    cmd,
   output crcfr_pkg::status_type status,
   input  logic                  req_type,
   input  logic [7:0]            rx_byte,
   output logic                  frame_ok,
   output logic [7:0]            ctrl_byte [crcfr_pkg::CTRL_BYTES],
   output logic [1:0]            fuel_mode_code,
   output logic                  emergency_flag,
   output logic                  link_fault
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int POS_W = $clog2(FRAME_BYTES + 1);

   logic [7:0]       store_ff [FRAME_BYTES];
   logic [POS_W-1:0] wpos_ff;
   logic [7:0]       idle_ff;
   logic [IDX_W-1:0] walk_ff;
   logic [7:0]       crc_ff;
   logic [15:0]      reject_ff;
   logic [7:0]       ctrl_ff [crcfr_pkg::CTRL_BYTES];
   logic [1:0]       mode_ff;
   logic             emerg_ff;
   logic             fault_ff;
   logic             ok_ff;

   logic [7:0]       named_byte [crcfr_pkg::NAMED_BYTES];
   logic [8:0]       idle_next;
   logic             room;
   logic             good;
   logic [15:0]      reject_next;
   logic             link_lost;
   logic [1:0]       mode_next;

   // Frame positions past the frame size read as zero.
   for (genvar k = 0; k < crcfr_pkg::NAMED_BYTES; k++) begin : g_named
      if (k < FRAME_BYTES) begin : g_in
         assign named_byte[k] = store_ff[k];
      end else begin : g_out
         assign named_byte[k] = '0;
      end
   end

   assign idle_next = {1'b0, idle_ff} + {8'd0, !req_type};
   assign room      = (wpos_ff < POS_W'(FRAME_BYTES));

   assign status.frame_end = (idle_next > {1'b0, cfg.idle_tick_limit});
   assign status.walk_last = (walk_ff == IDX_W'(FRAME_BYTES - 2));

   assign good = (store_ff[FRAME_BYTES-2] == cfg.end_marker) &&
                 (crc_ff == store_ff[FRAME_BYTES-1]);

   assign reject_next = (reject_ff == crcfr_pkg::REJECT_COUNT_MAX) ? reject_ff
                                                                 : reject_ff + 16'd1;
   assign link_lost   = (reject_next > cfg.reject_limit);

   always_comb begin
      priority if (named_byte[crcfr_pkg::BTN_OFF_POS] == crcfr_pkg::BUTTON_PRESSED) begin
         mode_next = crcfr_pkg::MODE_OFF;
      end else if (named_byte[crcfr_pkg::BTN_PREPARE_POS] == crcfr_pkg::BUTTON_PRESSED) begin
         mode_next = crcfr_pkg::MODE_PREPARE;
      end else if (named_byte[crcfr_pkg::BTN_RACE_POS] == crcfr_pkg::BUTTON_PRESSED) begin
         mode_next = crcfr_pkg::MODE_RACE;
      end else begin
         mode_next = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            store_ff[i] <= '0;
         end
         for (int i = 0; i < crcfr_pkg::CTRL_BYTES; i++) begin
            ctrl_ff[i] <= '0;
         end
         wpos_ff   <= '0;
         idle_ff   <= '0;
         reject_ff <= '0;
         mode_ff   <= crcfr_pkg::MODE_NONE;
         emerg_ff  <= 1'b0;
         fault_ff  <= 1'b1;
      end else begin
         if (cmd.accept) begin
            if (req_type && room) begin
               store_ff[wpos_ff[IDX_W-1:0]] <= rx_byte;
               wpos_ff <= wpos_ff + POS_W'(1);
            end
            if (!status.frame_end) begin
               idle_ff <= idle_next[7:0];
            end
         end
         if (cmd.finish) begin
            if (good) begin
               for (int i = 0; i < crcfr_pkg::CTRL_BYTES; i++) begin
                  ctrl_ff[i] <= named_byte[i];
               end
               mode_ff   <= mode_next;
               emerg_ff  <= (named_byte[crcfr_pkg::POWER_POS] != crcfr_pkg::POWER_ON);
               fault_ff  <= 1'b0;
               reject_ff <= '0;
            end else begin
               reject_ff <= reject_next;
               if (link_lost) begin
                  for (int i = 0; i < crcfr_pkg::CTRL_BYTES; i++) begin
                     ctrl_ff[i] <= '0;
                  end
                  emerg_ff <= 1'b1;
                  fault_ff <= 1'b1;
               end
            end
            // drop the buffered frame
            for (int i = 0; i < FRAME_BYTES; i++) begin
               store_ff[i] <= '0;
            end
            wpos_ff <= '0;
            idle_ff <= '0;
         end
      end
   end

   // CRC walk and verdict carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         crc_ff  <= crcfr_pkg::CRC_INIT;
         walk_ff <= '0;
      end else if (cmd.walk) begin
         crc_ff  <= crcfr_pkg::crc8_byte(crc_ff, store_ff[walk_ff]);
         walk_ff <= walk_ff + IDX_W'(1);
      end
      if (cmd.finish) begin
         ok_ff <= good;
      end
   end

   assign frame_ok       = ok_ff;
   assign ctrl_byte      = ctrl_ff;
   assign fuel_mode_code = mode_ff;
   assign emergency_flag = emerg_ff;
   assign link_fault     = fault_ff;

endmodule

>>> rtl/crc_checked_frame_receiver.sv
// Frame receiver for a polled serial link with idle-timeout framing and CRC-8 check.
// req channel: one transaction per polling tick; req_type high means rx_byte holds
//   a received byte, which goes to the next free frame position (extra bytes drop).
// rsp channel: one transaction per frame end, carrying the verdict and the latched
//   controls, fuel mode code, emergency and link fault after the frame is handled.
// APB port: idle tick limit at 0x0, reject limit at 0x4, end marker at 0x8;
//   write only while the block is idle. pready is tied high.
// Sequence: a tick that does not end a frame leaves the block ready for the next tick.
//   After a tick that ends a frame, req.ready stays low through the CRC walk over the
//   first FRAME_BYTES - 1 stored bytes (one CRC-8 byte update per cycle) and the step
//   that applies the verdict, which holds while a result is still pending; rsp.valid
//   rises in the cycle after that step, together with the verdict and controls.
// Stall: the result waits in the output register while ticks keep being taken; a
//   later frame end holds in its final step until the pending result is taken.
// Reset: clears the frame buffer, the fill, idle and reject counters, the latched
//   controls and the mode code, raises the link fault and restores the register defaults.
module crc_checked_frame_receiver #(
   parameter int FRAME_BYTES = crcfr_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   crcfr_req_if.sink                        req,
   crcfr_rsp_if.source                      rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crcfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   crcfr_pkg::cfg_type    cfg;
   crcfr_pkg::cmd_type    cmd;
   crcfr_pkg::status_type status;
   logic [7:0]            ctrl_byte [crcfr_pkg::CTRL_BYTES];

   // register file
   crcfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencing: tick acceptance, CRC walk, verdict and result hand-off
   crcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame buffer, CRC, link state; its state registers double as the result payload
   crcfr_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req.req_type),
      .rx_byte        (req.rx_byte),
      .frame_ok       (rsp.frame_ok),
      .ctrl_byte      (ctrl_byte),
      .fuel_mode_code (rsp.fuel_mode_code),
      .emergency_flag (rsp.emergency_flag),
      .link_fault     (rsp.link_fault)
   );

   // map the latched control bytes onto their named fields
   assign rsp.half_throttle      = ctrl_byte[0];
   assign rsp.full_throttle      = ctrl_byte[1];
   assign rsp.horn_button        = ctrl_byte[2];
   assign rsp.speed_reset_button = ctrl_byte[3];
   assign rsp.power_request      = ctrl_byte[4];
   assign rsp.supercap_close     = ctrl_byte[5];

endmodule

>>> rtl/crcfr_checker.sv
module crcfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       frame_ok,
   input logic [7:0] half_throttle,
   input logic [7:0] full_throttle,
   input logic [7:0] horn_button,
   input logic [7:0] speed_reset_button,
   input logic [7:0] power_request,
   input logic [7:0] supercap_close,
   input logic       emergency_flag,
   input logic       link_fault
);

   // hold a pending result until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_good_clears_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_ok |-> !link_fault &&
         (emergency_flag == (power_request != crcfr_pkg::POWER_ON)))
      else $error("good frame with wrong fault or emergency");

   a_fault_zero_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && link_fault |-> (half_throttle == 8'd0) && (full_throttle == 8'd0) &&
         (horn_button == 8'd0) && (speed_reset_button == 8'd0) &&
         (power_request == 8'd0) && (supercap_close == 8'd0))
      else $error("controls not zero under link fault");

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .frame_ok           (rsp.frame_ok),
   .half_throttle      (rsp.half_throttle),
   .full_throttle      (rsp.full_throttle),
   .horn_button        (rsp.horn_button),
   .speed_reset_button (rsp.speed_reset_button),
   .power_request      (rsp.power_request),
   .supercap_close     (rsp.supercap_close),
   .emergency_flag     (rsp.emergency_flag),
   .link_fault         (rsp.link_fault)
);
